// ===== sv/lob_pkg.sv =====
`default_nettype none
package lob_pkg;

  localparam logic REQ_NEW    = 1'b0;
  localparam logic REQ_CANCEL = 1'b1;

  localparam logic [1:0] OK_LONG_OPEN   = 2'd0;
  localparam logic [1:0] OK_SHORT_OPEN  = 2'd1;
  localparam logic [1:0] OK_LONG_CLOSE  = 2'd2;
  localparam logic [1:0] OK_SHORT_CLOSE = 2'd3;

  localparam logic [2:0] RK_FILL      = 3'd0;
  localparam logic [2:0] RK_SUMMARY   = 3'd1;
  localparam logic [2:0] RK_RESTED    = 3'd2;
  localparam logic [2:0] RK_CANCELLED = 3'd3;
  localparam logic [2:0] RK_CANCEL_NF = 3'd4;
  localparam logic [2:0] RK_REJECTED  = 3'd5;
  localparam logic [2:0] RK_FULL      = 3'd6;

  localparam logic [3:0] TC_LONG_OPEN_RED     = 4'd0;
  localparam logic [3:0] TC_DOUBLE_OPEN_RED   = 4'd1;
  localparam logic [3:0] TC_LONG_SWITCH_RED   = 4'd2;
  localparam logic [3:0] TC_SHORT_OPEN_GREEN  = 4'd3;
  localparam logic [3:0] TC_DOUBLE_OPEN_GREEN = 4'd4;
  localparam logic [3:0] TC_SHORT_SWITCH_GREEN = 4'd5;
  localparam logic [3:0] TC_LONG_CLOSE_GREEN  = 4'd6;
  localparam logic [3:0] TC_DOUBLE_CLOSE_GREEN = 4'd7;
  localparam logic [3:0] TC_SHORT_CLOSE_RED   = 4'd8;
  localparam logic [3:0] TC_DOUBLE_CLOSE_RED  = 4'd9;

  localparam logic REG_UPPER = 1'b0;
  localparam logic REG_LOWER = 1'b1;

  localparam int          RES_AW    = 6;
  localparam logic [5:0]  MAX_FILLS = 6'd63;

endpackage
`default_nettype wire

// ===== sv/lob_in_if.sv =====
`default_nettype none
interface lob_in_if #(
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 16
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [1:0]            order_kind;
  logic [PRICE_BITS-1:0] order_price;
  logic [QTY_BITS-1:0]   order_qty;
  logic [15:0]           customer_id;

  modport source (output valid, req_type, order_kind, order_price, order_qty, customer_id,
                  input ready);
  modport sink (input valid, req_type, order_kind, order_price, order_qty, customer_id,
                output ready);
endinterface
`default_nettype wire

// ===== sv/lob_out_if.sv =====
`default_nettype none
interface lob_out_if #(
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 16
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              result_kind;
  logic [15:0]             buyer_id;
  logic [15:0]             seller_id;
  logic [PRICE_BITS-1:0]   trade_price;
  logic [QTY_BITS-1:0]     trade_qty;
  logic [3:0]              trade_class;
  logic signed [PRICE_BITS:0] best_bid;
  logic [QTY_BITS-1:0]     best_bid_qty;
  logic signed [PRICE_BITS:0] best_ask;
  logic [QTY_BITS-1:0]     best_ask_qty;
  logic                    last;

  modport source (output valid, result_kind, buyer_id, seller_id, trade_price, trade_qty,
                  trade_class, best_bid, best_bid_qty, best_ask, best_ask_qty, last,
                  input ready);
  modport sink (input valid, result_kind, buyer_id, seller_id, trade_price, trade_qty,
                trade_class, best_bid, best_bid_qty, best_ask, best_ask_qty, last,
                output ready);
endinterface
`default_nettype wire

// ===== sv/lob_front.sv =====
`default_nettype none
module lob_front #(
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 16,
  parameter int QW         = PRICE_BITS + QTY_BITS + 21
) (
  lob_in_if.sink           req_i,
  input  wire logic [PRICE_BITS-1:0] upper_i,
  input  wire logic [PRICE_BITS-1:0] lower_i,
  output logic             push_valid_o,
  input  wire logic        push_ready_i,
  output logic [QW-1:0]    push_data_o
);
  import lob_pkg::*;

  logic is_bid;
  logic band_bad;

  assign is_bid   = (req_i.order_kind == OK_LONG_OPEN) || (req_i.order_kind == OK_SHORT_CLOSE);
  assign band_bad = (req_i.req_type == REQ_NEW) &&
                    ((req_i.order_price > upper_i) || (req_i.order_price < lower_i));

  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;
  assign push_data_o  = {req_i.req_type, req_i.order_kind, req_i.order_price, req_i.order_qty,
                         req_i.customer_id, is_bid, band_bad};
endmodule
`default_nettype wire

// ===== sv/lob_queue.sv =====
`default_nettype none
module lob_queue #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output logic              push_ready_o,
  input  wire logic [W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  wire logic         pop_ready_i,
  output logic [W-1:0]      pop_data_o
);
  logic [W-1:0] slot_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= push_data_i;
  end
endmodule
`default_nettype wire

// ===== sv/lob_engine.sv =====
`default_nettype none
module lob_engine #(
  parameter int BOOK_DEPTH = 32,
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 16,
  parameter int QW         = PRICE_BITS + QTY_BITS + 21
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  output logic               q_ready_o,
  input  wire logic [QW-1:0] q_data_i,
  lob_out_if.source          res_o
);
  import lob_pkg::*;

  localparam int P   = PRICE_BITS;
  localparam int Q   = QTY_BITS;
  localparam int EW  = P + Q + 18;
  localparam int AW  = $clog2(BOOK_DEPTH);
  localparam int UW  = $clog2(BOOK_DEPTH + 1);
  localparam int TW  = Q + 6;
  localparam int RBW = 3 + 16 + 16 + P + Q + 4;
  localparam int RD  = 2 ** RES_AW;
  localparam int RCW = RES_AW + 1;

  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_CLASS    = 19'h00002,
    S_INS_RD   = 19'h00004,
    S_INS_CMP  = 19'h00008,
    S_INS_LAST = 19'h00010,
    S_CAN_RD   = 19'h00020,
    S_CAN_CMP  = 19'h00040,
    S_DROP_CHK = 19'h00080,
    S_DROP_RD  = 19'h00100,
    S_DROP_WR  = 19'h00200,
    S_M_RD     = 19'h00400,
    S_M_CMP    = 19'h00800,
    S_M_END    = 19'h01000,
    S_TOP      = 19'h02000,
    S_TOP_RD   = 19'h04000,
    S_TOP_CMP  = 19'h08000,
    S_OUT_RD   = 19'h10000,
    S_OUT_LD   = 19'h20000,
    S_OUT_SHOW = 19'h40000
  } state_e;

  state_e state_q, state_d, dret_q, dret_d;

  logic         req_q, isbid_q, bad_q;
  logic [1:0]   kind_q;
  logic [P-1:0] price_q;
  logic [Q-1:0] qty_q;
  logic [15:0]  cust_q;

  logic [UW-1:0] bid_used_q, bid_used_d, ask_used_q, ask_used_d, idx_q, idx_d;
  logic          dside_q, dside_d, apend_q, apend_d;
  logic [5:0]    fills_q, fills_d;
  logic [TW-1:0] total_q, total_d, ko_q, ko_d, dp_q, dp_d, dk_q, dk_d, kp_q, kp_d;
  logic [P-1:0]  lastpx_q, lastpx_d;
  logic [RES_AW:0] nres_q, nres_d, optr_q, optr_d;
  logic          bact_q, bact_d, aact_q, aact_d;
  logic [P:0]    bpx_q, bpx_d, apx_q, apx_d;
  logic [Q-1:0]  bsum_q, bsum_d, asum_q, asum_d;

  logic [EW-1:0] bid_mem [BOOK_DEPTH];
  logic [EW-1:0] ask_mem [BOOK_DEPTH];
  logic [EW-1:0] brd_q, ard_q;
  logic [RBW-1:0] res_mem [RD];
  logic [RBW-1:0] rbrd_q;

  logic          swe, wsel;
  logic [AW-1:0] swa, ra;
  logic [EW-1:0] swd;
  logic          bwe, awe;
  logic          rbwe;
  logic [RES_AW-1:0] rbra;
  logic [2:0]    pk;
  logic [15:0]   pbuy, psell;
  logic [P-1:0]  ppx;
  logic [Q-1:0]  pqty;
  logic [3:0]    pcls, cls;
  logic          fin, load;

  logic [EW-1:0] srd, drd, new_e;
  logic [P-1:0]  b_px, a_px, e_px;
  logic [Q-1:0]  b_qt, a_qt, fill_c, nb, na;
  logic [UW-1:0] sused, dused, idx_m1, idx_p1;
  logic [TW-1:0] total_c;
  logic [Q:0]    bsum_x, asum_x;

  logic         ov_q, olast_q;
  logic [RBW-1:0] opay_q;
  logic [P:0]   obb_q, oba_q;
  logic [Q-1:0] obbq_q, obaq_q;

  assign new_e  = {price_q, qty_q, cust_q, kind_q};
  assign sused  = isbid_q ? bid_used_q : ask_used_q;
  assign dused  = dside_q ? bid_used_q : ask_used_q;
  assign srd    = isbid_q ? brd_q : ard_q;
  assign drd    = dside_q ? brd_q : ard_q;
  assign e_px   = srd[EW-1 -: P];
  assign b_px   = brd_q[EW-1 -: P];
  assign a_px   = ard_q[EW-1 -: P];
  assign b_qt   = brd_q[Q+17 -: Q];
  assign a_qt   = ard_q[Q+17 -: Q];
  assign fill_c = (b_qt < a_qt) ? b_qt : a_qt;
  assign nb     = b_qt - fill_c;
  assign na     = a_qt - fill_c;
  assign idx_m1 = idx_q - UW'(1);
  assign idx_p1 = idx_q + UW'(1);
  assign total_c = total_q + TW'(fill_c);
  assign bsum_x = {1'b0, bsum_q} + {1'b0, b_qt};
  assign asum_x = {1'b0, asum_q} + {1'b0, a_qt};
  assign bwe    = swe && wsel;
  assign awe    = swe && !wsel;
  assign load   = q_valid_i && q_ready_o;

  always_comb begin
    unique case (kind_q)
      OK_LONG_OPEN: begin
        cls = (total_q == ko_q) ? TC_DOUBLE_OPEN_RED :
              (total_q == dp_q) ? TC_LONG_SWITCH_RED : TC_LONG_OPEN_RED;
      end
      OK_SHORT_OPEN: begin
        cls = (total_q == dk_q) ? TC_DOUBLE_OPEN_GREEN :
              (total_q == kp_q) ? TC_SHORT_SWITCH_GREEN : TC_SHORT_OPEN_GREEN;
      end
      OK_LONG_CLOSE: begin
        cls = (total_q == kp_q) ? TC_DOUBLE_CLOSE_GREEN : TC_LONG_CLOSE_GREEN;
      end
      default: begin
        cls = (total_q == dp_q) ? TC_DOUBLE_CLOSE_RED : TC_SHORT_CLOSE_RED;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;     dret_d = dret_q;
    bid_used_d = bid_used_q; ask_used_d = ask_used_q; idx_d = idx_q;
    dside_d = dside_q;     apend_d = apend_q;
    fills_d = fills_q;     total_d = total_q;
    ko_d = ko_q; dp_d = dp_q; dk_d = dk_q; kp_d = kp_q;
    lastpx_d = lastpx_q;   nres_d = nres_q; optr_d = optr_q;
    bact_d = bact_q; aact_d = aact_q; bpx_d = bpx_q; apx_d = apx_q;
    bsum_d = bsum_q; asum_d = asum_q;
    swe = 1'b0; wsel = isbid_q; swa = idx_q[AW-1:0]; swd = new_e; ra = '0;
    rbwe = 1'b0; rbra = optr_q[RES_AW-1:0];
    pk = RK_RESTED; pbuy = '0; psell = '0; ppx = '0; pqty = '0; pcls = TC_LONG_OPEN_RED;
    fin = 1'b0; q_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) state_d = S_CLASS;
      end
      S_CLASS: begin
        fills_d = '0; total_d = '0; ko_d = '0; dp_d = '0; dk_d = '0; kp_d = '0;
        lastpx_d = '0; idx_d = '0;
        if (req_q == REQ_CANCEL) begin
          if (sused == '0) begin
            rbwe = 1'b1; pk = RK_CANCEL_NF; state_d = S_TOP;
          end else begin
            state_d = S_CAN_RD;
          end
        end else if (bad_q) begin
          rbwe = 1'b1; pk = RK_REJECTED; state_d = S_TOP;
        end else if (sused == UW'(BOOK_DEPTH)) begin
          rbwe = 1'b1; pk = RK_FULL; state_d = S_TOP;
        end else if (qty_q == '0) begin
          rbwe = 1'b1; pk = RK_RESTED; state_d = S_TOP;
        end else if (sused == '0) begin
          swe = 1'b1; swa = '0;
          if (isbid_q) bid_used_d = bid_used_q + UW'(1);
          else ask_used_d = ask_used_q + UW'(1);
          state_d = S_M_RD;
        end else begin
          idx_d = sused; state_d = S_INS_RD;
        end
      end
      S_INS_RD: begin
        ra = idx_m1[AW-1:0]; state_d = S_INS_CMP;
      end
      S_INS_CMP: begin
        swe = 1'b1;
        if (isbid_q ? (e_px < price_q) : (e_px > price_q)) begin
          swd = srd;
          if (idx_q == UW'(1)) state_d = S_INS_LAST;
          else begin
            idx_d = idx_m1; state_d = S_INS_RD;
          end
        end else begin
          if (isbid_q) bid_used_d = bid_used_q + UW'(1);
          else ask_used_d = ask_used_q + UW'(1);
          state_d = S_M_RD;
        end
      end
      S_INS_LAST: begin
        swe = 1'b1; swa = '0;
        if (isbid_q) bid_used_d = bid_used_q + UW'(1);
        else ask_used_d = ask_used_q + UW'(1);
        state_d = S_M_RD;
      end
      S_CAN_RD: begin
        ra = idx_q[AW-1:0]; state_d = S_CAN_CMP;
      end
      S_CAN_CMP: begin
        if (srd == new_e) begin
          rbwe = 1'b1; pk = RK_CANCELLED;
          dside_d = isbid_q; apend_d = 1'b0; dret_d = S_TOP; state_d = S_DROP_CHK;
        end else if (idx_p1 == sused) begin
          rbwe = 1'b1; pk = RK_CANCEL_NF; state_d = S_TOP;
        end else begin
          idx_d = idx_p1; state_d = S_CAN_RD;
        end
      end
      S_DROP_CHK: begin
        if (idx_p1 == dused) fin = 1'b1;
        else state_d = S_DROP_RD;
      end
      S_DROP_RD: begin
        ra = idx_p1[AW-1:0]; state_d = S_DROP_WR;
      end
      S_DROP_WR: begin
        swe = 1'b1; wsel = dside_q; swd = drd;
        idx_d = idx_p1;
        if (idx_q + UW'(2) == dused) fin = 1'b1;
        else state_d = S_DROP_RD;
      end
      S_M_RD: begin
        if (fills_q == MAX_FILLS || bid_used_q == '0 || ask_used_q == '0) state_d = S_M_END;
        else state_d = S_M_CMP;
      end
      S_M_CMP: begin
        if (b_px < a_px) begin
          state_d = S_M_END;
        end else begin
          if (isbid_q) begin
            if (ard_q[1:0] == OK_SHORT_OPEN) ko_d = ko_q + TW'(fill_c);
            else dp_d = dp_q + TW'(fill_c);
          end else begin
            if (brd_q[1:0] == OK_LONG_OPEN) dk_d = dk_q + TW'(fill_c);
            else kp_d = kp_q + TW'(fill_c);
          end
          rbwe = 1'b1; pk = RK_FILL; pbuy = brd_q[17:2]; psell = ard_q[17:2];
          ppx = isbid_q ? a_px : b_px; pqty = fill_c;
          fills_d = fills_q + 6'd1; total_d = total_c; lastpx_d = ppx;
          idx_d = '0; dret_d = S_M_RD; state_d = S_DROP_CHK;
          if (nb == '0) begin
            dside_d = 1'b1; apend_d = (na == '0);
            if (na != '0) begin
              swe = 1'b1; wsel = 1'b0; swa = '0; swd = {ard_q[EW-1 -: P], na, ard_q[17:0]};
            end
          end else begin
            dside_d = 1'b0; apend_d = 1'b0;
            swe = 1'b1; wsel = 1'b1; swa = '0; swd = {brd_q[EW-1 -: P], nb, brd_q[17:0]};
          end
        end
      end
      S_M_END: begin
        rbwe = 1'b1;
        if (fills_q == '0) pk = RK_RESTED;
        else begin
          pk = RK_SUMMARY; ppx = lastpx_q; pcls = cls;
          pqty = (total_q > TW'({Q{1'b1}})) ? {Q{1'b1}} : total_q[Q-1:0];
        end
        state_d = S_TOP;
      end
      S_TOP: begin
        idx_d = '0;
        bact_d = (bid_used_q != '0); aact_d = (ask_used_q != '0);
        bpx_d = '1; apx_d = '1; bsum_d = '0; asum_d = '0;
        if (bid_used_q == '0 && ask_used_q == '0) state_d = S_OUT_RD;
        else state_d = S_TOP_RD;
      end
      S_TOP_RD: begin
        ra = idx_q[AW-1:0]; state_d = S_TOP_CMP;
      end
      S_TOP_CMP: begin
        if (bact_q) begin
          if (idx_q == '0 || {1'b0, b_px} == bpx_q) begin
            bpx_d = {1'b0, b_px};
            bsum_d = bsum_x[Q] ? {Q{1'b1}} : bsum_x[Q-1:0];
            if (idx_p1 == bid_used_q) bact_d = 1'b0;
          end else bact_d = 1'b0;
        end
        if (aact_q) begin
          if (idx_q == '0 || {1'b0, a_px} == apx_q) begin
            apx_d = {1'b0, a_px};
            asum_d = asum_x[Q] ? {Q{1'b1}} : asum_x[Q-1:0];
            if (idx_p1 == ask_used_q) aact_d = 1'b0;
          end else aact_d = 1'b0;
        end
        idx_d = idx_p1;
        if (!bact_d && !aact_d) state_d = S_OUT_RD;
        else state_d = S_TOP_RD;
      end
      S_OUT_RD: begin
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        state_d = S_OUT_SHOW;
      end
      S_OUT_SHOW: begin
        if (res_o.ready) begin
          optr_d = optr_q + RCW'(1);
          if (olast_q) begin
            nres_d = '0; optr_d = '0; state_d = S_IDLE;
          end else state_d = S_OUT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) begin
      if (dside_q) bid_used_d = bid_used_q - UW'(1);
      else ask_used_d = ask_used_q - UW'(1);
      if (apend_q) begin
        apend_d = 1'b0; dside_d = 1'b0; idx_d = '0; state_d = S_DROP_CHK;
      end else state_d = dret_q;
    end
    if (rbwe) nres_d = nres_q + RCW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;   dret_q <= S_TOP;
      bid_used_q <= '0;    ask_used_q <= '0;  idx_q <= '0;
      dside_q <= 1'b0;     apend_q <= 1'b0;
      fills_q <= '0;       total_q <= '0;
      ko_q <= '0; dp_q <= '0; dk_q <= '0; kp_q <= '0;
      nres_q <= '0;        optr_q <= '0;
      bact_q <= 1'b0;      aact_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;  dret_q <= dret_d;
      bid_used_q <= bid_used_d; ask_used_q <= ask_used_d; idx_q <= idx_d;
      dside_q <= dside_d;  apend_q <= apend_d;
      fills_q <= fills_d;  total_q <= total_d;
      ko_q <= ko_d; dp_q <= dp_d; dk_q <= dk_d; kp_q <= kp_d;
      nres_q <= nres_d;    optr_q <= optr_d;
      bact_q <= bact_d;    aact_q <= aact_d;
      if (state_q == S_OUT_LD) ov_q <= 1'b1;
      else if (res_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    lastpx_q <= lastpx_d;
    bpx_q <= bpx_d; apx_q <= apx_d; bsum_q <= bsum_d; asum_q <= asum_d;
    if (load) begin
      {req_q, kind_q, price_q, qty_q, cust_q, isbid_q, bad_q} <= q_data_i;
    end
    if (state_q == S_OUT_LD) begin
      opay_q  <= rbrd_q;
      obb_q   <= bpx_q;  obbq_q <= bsum_q;
      oba_q   <= apx_q;  obaq_q <= asum_q;
      olast_q <= (optr_q + RCW'(1) == nres_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (bwe) bid_mem[swa] <= swd;
    brd_q <= bid_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (awe) ask_mem[swa] <= swd;
    ard_q <= ask_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (rbwe) res_mem[nres_q[RES_AW-1:0]] <= {pk, pbuy, psell, ppx, pqty, pcls};
    rbrd_q <= res_mem[rbra];
  end

  assign res_o.valid        = ov_q;
  assign res_o.result_kind  = opay_q[RBW-1 -: 3];
  assign res_o.buyer_id     = opay_q[RBW-4 -: 16];
  assign res_o.seller_id    = opay_q[RBW-20 -: 16];
  assign res_o.trade_price  = opay_q[Q+P+3 -: P];
  assign res_o.trade_qty    = opay_q[Q+3 -: Q];
  assign res_o.trade_class  = opay_q[3:0];
  assign res_o.best_bid     = obb_q;
  assign res_o.best_bid_qty = obbq_q;
  assign res_o.best_ask     = oba_q;
  assign res_o.best_ask_qty = obaq_q;
  assign res_o.last         = olast_q;
endmodule
`default_nettype wire

// ===== sv/limit_order_book_matcher_core.sv =====
// Limit order book matcher with price-time priority.
// Requests arrive on req_i (valid/ready); one transfer is one new order or cancel.
// Results leave on res_o (valid/ready); each request yields one or more result
// transfers, the final one marked by last, and every one carries the best bid and
// ask after the whole request.
// The price band registers sit on the APB port: upper limit at 0x0, lower at 0x4.
// A front stage classifies requests into a two-entry queue, so up to two requests
// are taken while the execution unit is busy.
// The execution unit keeps each book side in a memory sorted by price, with one
// write port and one read port. Insertion moves one entry per read and compare
// step; a removal reads and rewrites each entry behind the removed one; each fill
// passes a read, a compare and a drop check plus its removals; the top-of-book
// scan reads and compares each entry at the best price. Each result transfer is
// played out of the result buffer through a read, a load and a show state.
// After reset both sides are empty, the band is the full price range and no result
// is pending. When the receiver holds ready low the current result stays on the
// port and the execution unit waits; the queue then fills and req_i.ready drops.
`default_nettype none
module limit_order_book_matcher_core #(
  parameter int BOOK_DEPTH = 32,
  parameter int PRICE_BITS = 20,
  parameter int QTY_BITS   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lob_in_if.sink           req_i,
  lob_out_if.source        res_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lob_pkg::*;

  localparam int QW = PRICE_BITS + QTY_BITS + 21;

  logic [PRICE_BITS-1:0] upper_q, lower_q;
  logic                  fq_valid, fq_ready, qe_valid, qe_ready;
  logic [QW-1:0]         fq_data, qe_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LOWER) ? 32'(lower_q) : 32'(upper_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= '1;
      lower_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_UPPER) upper_q <= pwdata[PRICE_BITS-1:0];
      else lower_q <= pwdata[PRICE_BITS-1:0];
    end
  end

  lob_front #(.PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS), .QW(QW)) u_front (
    .req_i        (req_i),
    .upper_i      (upper_q),
    .lower_i      (lower_q),
    .push_valid_o (fq_valid),
    .push_ready_i (fq_ready),
    .push_data_o  (fq_data)
  );

  lob_queue #(.W(QW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qe_valid),
    .pop_ready_i  (qe_ready),
    .pop_data_o   (qe_data)
  );

  lob_engine #(
    .BOOK_DEPTH(BOOK_DEPTH), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS), .QW(QW)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (qe_valid),
    .q_ready_o (qe_ready),
    .q_data_i  (qe_data),
    .res_o     (res_o)
  );

  a_nonfill_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.result_kind != RK_FILL |->
    res_o.buyer_id == 16'd0 && res_o.seller_id == 16'd0)
    else $error("Non-fill result carries customer ids.");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.result_kind == RK_RESTED || res_o.result_kind == RK_CANCELLED ||
    res_o.result_kind == RK_CANCEL_NF || res_o.result_kind == RK_REJECTED ||
    res_o.result_kind == RK_FULL) |-> res_o.last)
    else $error("Single-result request not marked last.");

  a_fill_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.result_kind == RK_FILL |-> !res_o.last)
    else $error("Fill marked as the final result.");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.result_kind == RK_SUMMARY |-> res_o.last)
    else $error("Trade summary not marked last.");
endmodule
`default_nettype wire
